// ===== design/sdtl_pkg.sv =====
package sdtl_pkg;

	localparam int ID_W      = 4;
	localparam int KEY_W     = 32;
	localparam int CNT_OUT_W = 5;

	typedef enum logic [1:0] {
		FUNC_APPEND = 2'd0,
		FUNC_SORTED = 2'd1,
		FUNC_REMOVE = 2'd2,
		FUNC_HEAD   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_LISTED     = 2'd1,
		ST_NOT_LISTED = 2'd2,
		ST_EMPTY      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_WALK,
		S_LINK1,
		S_LINK2,
		S_RM_LINK,
		S_RM_HEAD,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		RD_FIRST,
		RD_NEXT,
		RD_ID
	} rd_sel_t;

	typedef struct packed {
		logic    latch;
		logic    set_status;
		status_t status;
		logic    set_tail;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    walk_end;
		logic    link1;
		logic    link2;
		logic    rm_link;
		logic    rm_head;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  id_ok;
		logic  is_member;
		logic  empty;
		logic  first_null;
		logic  walk_go;
		logic  out_free;
	} sts_t;

endpackage

// ===== design/sorted_doubly_linked_task_list.sv =====
// Channel | Direction | Handshake          | Payload
// in      | receive   | in_valid/in_stall  | func, item_id, item_value
// out     | send      | out_valid/out_stall| status, head_id, head_value, count
//
// One transaction in, one result out. Read head and rejected requests go from decode
// to the result; append and remove pass LINK1/LINK2 or RM_LINK/RM_HEAD, sorted insert also
// walks the list first (at most MAX_ITEMS - 1 entries compared) via the link memories' single read port.
// Reset (arst_n low) empties the list at once; link and key memories need no clearing.
// A held result waits in the output register; a new request is still taken meanwhile.
module sorted_doubly_linked_task_list #(
	parameter int MAX_ITEMS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      func,
	input  logic [sdtl_pkg::ID_W-1:0]       item_id,
	input  logic [sdtl_pkg::KEY_W-1:0]      item_value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      status,
	output logic [sdtl_pkg::ID_W-1:0]       head_id,
	output logic [sdtl_pkg::KEY_W-1:0]      head_value,
	output logic [sdtl_pkg::CNT_OUT_W-1:0]  count
);
	import sdtl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Controller: decode the request, step the list walk, sequence the link writes
	// and hand the result to the output register.
	sdtl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: link and key memories (one registered read a cycle), head/tail
	// pointers, membership flags, entry count and the output register.
	sdtl_dp #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.func       (func),
		.item_id    (item_id),
		.item_value (item_value),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.status     (status),
		.head_id    (head_id),
		.head_value (head_value),
		.count      (count)
	);

endmodule

// ===== design/sdtl_dp.sv =====
module sdtl_dp #(
	parameter int MAX_ITEMS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sdtl_pkg::cmd_t                  cmd,
	output sdtl_pkg::sts_t                  sts,
	input  logic [1:0]                      func,
	input  logic [sdtl_pkg::ID_W-1:0]       item_id,
	input  logic [sdtl_pkg::KEY_W-1:0]      item_value,
	input  logic                            out_stall,
	output logic                            out_valid,
	output logic [1:0]                      status,
	output logic [sdtl_pkg::ID_W-1:0]       head_id,
	output logic [sdtl_pkg::KEY_W-1:0]      head_value,
	output logic [sdtl_pkg::CNT_OUT_W-1:0]  count
);
	import sdtl_pkg::*;

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int LW = $clog2(MAX_ITEMS + 1);
	localparam logic [LW-1:0] NULL_LINK = LW'(MAX_ITEMS);

	// link memories and key store, no reset
	logic [LW-1:0]    next_mem [MAX_ITEMS];
	logic [LW-1:0]    prev_mem [MAX_ITEMS];
	logic [KEY_W-1:0] key_mem  [MAX_ITEMS];

	logic [LW-1:0]    next_rd_q, prev_rd_q;
	logic [KEY_W-1:0] key_rd_q;

	func_t            func_q;
	logic [ID_W-1:0]  id_q;
	logic [KEY_W-1:0] key_q;
	status_t          status_q;
	logic [LW-1:0]    cur_q, at_q, before_q;
	logic [KEY_W-1:0] head_key_q;
	logic             p_null_q;

	logic [LW-1:0]        first_q, last_q;
	logic [LW-1:0]        cnt_q;
	logic [MAX_ITEMS-1:0] member_q;
	logic                 out_valid_q;
	logic [1:0]           status_o_q;
	logic [ID_W-1:0]      head_id_q;
	logic [KEY_W-1:0]     head_value_q;
	logic [CNT_OUT_W-1:0] count_q;

	logic [AW-1:0] id_addr, rd_addr, next_wa, prev_wa;
	logic [LW-1:0] id_link, next_wd, prev_wd;
	logic          next_we, prev_we, id_ok, key_gt;

	assign id_addr = AW'(id_q);
	assign id_link = LW'(id_q);
	assign id_ok   = 32'(id_q) < MAX_ITEMS;
	assign key_gt  = key_rd_q > key_q;

	always_comb begin
		unique case (cmd.rd_sel)
			RD_FIRST: rd_addr = AW'(first_q);
			RD_NEXT:  rd_addr = AW'(next_rd_q);
			default:  rd_addr = id_addr;
		endcase
	end

	// one write per link memory per cycle
	always_comb begin
		next_we = 1'b0;
		next_wa = id_addr;
		next_wd = at_q;
		prev_we = 1'b0;
		prev_wa = id_addr;
		prev_wd = before_q;
		if (cmd.link1) begin
			next_we = 1'b1;
			prev_we = 1'b1;
		end else if (cmd.link2) begin
			next_we = before_q != NULL_LINK;
			next_wa = AW'(before_q);
			next_wd = id_link;
			prev_we = at_q != NULL_LINK;
			prev_wa = AW'(at_q);
			prev_wd = id_link;
		end else if (cmd.rm_link) begin
			next_we = prev_rd_q != NULL_LINK;
			next_wa = AW'(prev_rd_q);
			next_wd = next_rd_q;
			prev_we = next_rd_q != NULL_LINK;
			prev_wa = AW'(next_rd_q);
			prev_wd = prev_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (next_we) next_mem[next_wa] <= next_wd;
		if (prev_we) prev_mem[prev_wa] <= prev_wd;
		if (cmd.link1) key_mem[id_addr] <= key_q;
		if (cmd.rd_en) begin
			next_rd_q <= next_mem[rd_addr];
			prev_rd_q <= prev_mem[rd_addr];
			key_rd_q  <= key_mem[rd_addr];
		end
	end

	// transaction payload and walk registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q <= func_t'(func);
			id_q   <= item_id;
			key_q  <= item_value;
		end
		if (cmd.set_status) status_q <= cmd.status;
		if (cmd.rd_en) begin
			if (cmd.rd_sel == RD_FIRST) cur_q <= first_q;
			else                        cur_q <= next_rd_q;
		end
		if (cmd.set_tail) begin
			at_q     <= NULL_LINK;
			before_q <= last_q;
		end else if (cmd.walk_end) begin
			if (key_gt) begin
				at_q     <= NULL_LINK;
				before_q <= last_q;
			end else begin
				at_q     <= cur_q;
				before_q <= prev_rd_q;
			end
		end
		if (cmd.rm_link) p_null_q <= prev_rd_q == NULL_LINK;
		if (cmd.link2 && before_q == NULL_LINK) head_key_q <= key_q;
		if (cmd.rm_head && p_null_q) head_key_q <= key_rd_q;
		if (cmd.out_load) begin
			status_o_q   <= status_q;
			head_id_q    <= (cnt_q == '0) ? '0 : ID_W'(first_q);
			head_value_q <= (cnt_q == '0) ? '0 : head_key_q;
			count_q      <= CNT_OUT_W'(cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q     <= NULL_LINK;
			last_q      <= NULL_LINK;
			cnt_q       <= '0;
			member_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.link2) begin
				if (before_q == NULL_LINK) first_q <= id_link;
				if (at_q == NULL_LINK)     last_q  <= id_link;
				member_q[id_addr] <= 1'b1;
				cnt_q             <= cnt_q + 1'b1;
			end
			if (cmd.rm_link) begin
				if (prev_rd_q == NULL_LINK) first_q <= next_rd_q;
				if (next_rd_q == NULL_LINK) last_q  <= prev_rd_q;
				member_q[id_addr] <= 1'b0;
				cnt_q             <= cnt_q - 1'b1;
			end
			if (cmd.out_load)    out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign sts.func       = func_q;
	assign sts.id_ok      = id_ok;
	assign sts.is_member  = id_ok && member_q[id_addr];
	assign sts.empty      = cnt_q == '0;
	assign sts.first_null = first_q == NULL_LINK;
	assign sts.walk_go    = key_gt && (next_rd_q != NULL_LINK);
	assign sts.out_free   = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign status     = status_o_q;
	assign head_id    = head_id_q;
	assign head_value = head_value_q;
	assign count      = count_q;

endmodule

// ===== design/sdtl_ctrl.sv =====
module sdtl_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  sdtl_pkg::sts_t sts,
	output sdtl_pkg::cmd_t cmd
);
	import sdtl_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_DECODE;
			S_DECODE: begin
				unique case (sts.func)
					FUNC_APPEND: begin
						if (!sts.id_ok || sts.is_member) state_d = S_DONE;
						else                             state_d = S_LINK1;
					end
					FUNC_SORTED: begin
						if (!sts.id_ok || sts.is_member) state_d = S_DONE;
						else if (sts.first_null)         state_d = S_LINK1;
						else                             state_d = S_WALK;
					end
					FUNC_REMOVE: begin
						if (!sts.is_member) state_d = S_DONE;
						else                state_d = S_RM_LINK;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_WALK:    if (!sts.walk_go) state_d = S_LINK1;
			S_LINK1:   state_d = S_LINK2;
			S_LINK2:   state_d = S_DONE;
			S_RM_LINK: state_d = S_RM_HEAD;
			S_RM_HEAD: state_d = S_DONE;
			S_DONE:    if (sts.out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = state_q != S_IDLE;
		unique case (state_q)
			S_IDLE: cmd.latch = in_valid;
			S_DECODE: begin
				cmd.set_status = 1'b1;
				cmd.status     = ST_OK;
				unique case (sts.func)
					FUNC_APPEND: begin
						if (!sts.id_ok || sts.is_member) cmd.status   = ST_LISTED;
						else                             cmd.set_tail = 1'b1;
					end
					FUNC_SORTED: begin
						if (!sts.id_ok || sts.is_member) begin
							cmd.status = ST_LISTED;
						end else if (sts.first_null) begin
							cmd.set_tail = 1'b1;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_FIRST;
						end
					end
					FUNC_REMOVE: begin
						if (!sts.is_member) begin
							cmd.status = ST_NOT_LISTED;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_ID;
						end
					end
					default: if (sts.empty) cmd.status = ST_EMPTY;
				endcase
			end
			S_WALK: begin
				// advance one link a cycle while the visited key is larger and has a successor
				if (sts.walk_go) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_NEXT;
				end else begin
					cmd.walk_end = 1'b1;
				end
			end
			S_LINK1: cmd.link1 = 1'b1;
			S_LINK2: cmd.link2 = 1'b1;
			S_RM_LINK: begin
				// fetch the successor's key in case it becomes the head
				cmd.rm_link = 1'b1;
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = RD_NEXT;
			end
			S_RM_HEAD: cmd.rm_head  = 1'b1;
			S_DONE:    cmd.out_load = sts.out_free;
			default:   cmd = '0;
		endcase
	end

endmodule
